### hw/rtl/sha1_block_engine_registers_macros.svh
// ----------------------------------------------------------------------------
// SHA-1 block engine register window: assertion macros
// Shared property wrappers; each use expands to one labeled assertion.
// ----------------------------------------------------------------------------
`ifndef SHA1_BLOCK_ENGINE_REGISTERS_MACROS_SVH
`define SHA1_BLOCK_ENGINE_REGISTERS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define SHA1BE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define SHA1BE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sha1be_pkg.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine package
// Register map, sequencer states, control bundle and SHA-1 round helpers.
// ----------------------------------------------------------------------------
package sha1be_pkg;

    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 10;
    localparam int DIGEST_WORDS = 5;
    localparam int MSG_WORDS    = 16;
    localparam int CNT_W        = 7;

    // Register word indexes
    localparam logic [INDEX_W-1:0] IDX_CONFIG      = 10'd0;
    localparam logic [INDEX_W-1:0] IDX_RESET       = 10'd1;
    localparam logic [INDEX_W-1:0] IDX_IRQ_ACK     = 10'd2;
    localparam logic [INDEX_W-1:0] IDX_IRQ_EN      = 10'd3;
    localparam logic [INDEX_W-1:0] IDX_DIGEST_BASE = 10'd8;
    localparam logic [INDEX_W-1:0] IDX_DIGEST_LAST = 10'd12;
    localparam logic [INDEX_W-1:0] IDX_MSG_BASE    = 10'd16;
    localparam logic [INDEX_W-1:0] IDX_MSG_LAST    = 10'd31;
    localparam logic [INDEX_W-1:0] IDX_DMA_CTRL    = 10'd32;
    localparam logic [INDEX_W-1:0] IDX_DMA_ADDR    = 10'd33;
    localparam logic [INDEX_W-1:0] IDX_DMA_LEN     = 10'd35;

    // Config register bits
    localparam int CFG_BUSY      = 0;
    localparam int CFG_START     = 1;
    localparam int CFG_IRQ       = 2;
    localparam int CFG_CUSTOM_IV = 3;

    // Access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Sequencer counter end points
    localparam logic [CNT_W-1:0] CNT_LOAD_LAST  = 7'd16;
    localparam logic [CNT_W-1:0] CNT_ROUND_LAST = 7'd79;
    localparam logic [CNT_W-1:0] CNT_STORE_LAST = 7'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_STORE,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        RSP_DIRECT,
        RSP_DIGEST,
        RSP_MSG
    } rsp_kind_t;

    // Control bundle from the sequencer to the round unit
    typedef struct packed {
        logic             sched_load;
        logic             h_load;
        logic [2:0]       h_idx;
        logic             vars_init;
        logic             round_en;
        logic [CNT_W-1:0] rnd;
        logic [2:0]       sum_idx;
    } core_ctrl_t;

    function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function automatic logic [WORD_W-1:0] iv_word(input logic [2:0] idx);
        logic [WORD_W-1:0] w;
        case (idx)
            3'd0: w = 32'h67452301;
            3'd1: w = 32'hefcdab89;
            3'd2: w = 32'h98badcfe;
            3'd3: w = 32'h10325476;
            3'd4: w = 32'hc3d2e1f0;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] round_k(input logic [CNT_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        if (rnd < 7'd20) begin
            k = 32'h5a827999;
        end else if (rnd < 7'd40) begin
            k = 32'h6ed9eba1;
        end else if (rnd < 7'd60) begin
            k = 32'h8f1bbcdc;
        end else begin
            k = 32'hca62c1d6;
        end
        return k;
    endfunction

    function automatic logic [WORD_W-1:0] round_f(
        input logic [CNT_W-1:0]  rnd,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] c,
        input logic [WORD_W-1:0] d
    );
        logic [WORD_W-1:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

### hw/rtl/sha1be_req_if.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine request channel
// One bus access per transfer: kind, word index and write data.
// ----------------------------------------------------------------------------
interface sha1be_req_if;
    import sha1be_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [INDEX_W-1:0] word_index;
    logic [WORD_W-1:0]  write_data;

    modport source (output valid, output op, output word_index, output write_data,
                    input ready);
    modport sink   (input valid, input op, input word_index, input write_data,
                    output ready);
endinterface

### hw/rtl/sha1be_rsp_if.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine response channel
// One result per access: read data and interrupt level.
// ----------------------------------------------------------------------------
interface sha1be_rsp_if;
    import sha1be_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] read_data;
    logic              irq_line;

    modport source (output valid, output read_data, output irq_line, input ready);
    modport sink   (input valid, input read_data, input irq_line, output ready);
endinterface

### hw/rtl/sha1be_mem.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine word store
// Single-write, single-read memory with registered read data and per-entry
// valid bits; an entry never written since reset or clear reads as zero.
// ----------------------------------------------------------------------------
module sha1be_mem #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 clear,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [sha1be_pkg::WORD_W-1:0]        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [sha1be_pkg::WORD_W-1:0]        rdata
);
    import sha1be_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic              waddr_ok;
    logic              raddr_ok;

    assign waddr_ok = ({1'b0, waddr} < (AW + 1)'(DEPTH));
    assign raddr_ok = ({1'b0, raddr} < (AW + 1)'(DEPTH));

    // Mark written entries, drop all on clear
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we && waddr_ok)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (we && waddr_ok)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (raddr_ok)
        begin
            rd_data_reg  <= mem_reg[raddr];
            rd_valid_reg <= valid_reg[raddr];
        end
        else
        begin
            rd_data_reg  <= '0;
            rd_valid_reg <= 1'b0;
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;
endmodule

### hw/rtl/sha1be_core.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine round unit
// Message schedule shift line, working variables and chaining inputs; one
// compression round per cycle under sequencer control.
// ----------------------------------------------------------------------------
module sha1be_core (
    input  logic                          clk,
    input  sha1be_pkg::core_ctrl_t        ctrl,
    input  logic [sha1be_pkg::WORD_W-1:0] msg_word,
    input  logic [sha1be_pkg::WORD_W-1:0] h_word,
    output logic [sha1be_pkg::WORD_W-1:0] sum_word
);
    import sha1be_pkg::*;

    logic [WORD_W-1:0] sched_reg [MSG_WORDS];
    logic [WORD_W-1:0] hinit_reg [DIGEST_WORDS];
    logic [WORD_W-1:0] a_reg;
    logic [WORD_W-1:0] b_reg;
    logic [WORD_W-1:0] c_reg;
    logic [WORD_W-1:0] d_reg;
    logic [WORD_W-1:0] e_reg;
    logic [WORD_W-1:0] t_word;
    logic [WORD_W-1:0] mix_word;
    logic [WORD_W-1:0] new_w;

    // Round sum and next schedule word
    always_comb
    begin
        t_word = {a_reg[26:0], a_reg[31:27]} + round_f(ctrl.rnd, b_reg, c_reg, d_reg)
               + e_reg + round_k(ctrl.rnd) + sched_reg[0];
        mix_word = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
        new_w    = {mix_word[30:0], mix_word[31]};
    end

    // Schedule shift line: load message words, then advance one per round
    always_ff @(posedge clk)
    begin
        if (ctrl.sched_load || ctrl.round_en)
        begin
            for (int i = 0; i < MSG_WORDS - 1; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[MSG_WORDS - 1] <= ctrl.sched_load ? swap32(msg_word) : new_w;
        end
    end

    // Chaining input words
    always_ff @(posedge clk)
    begin
        if (ctrl.h_load && (ctrl.h_idx < 3'(DIGEST_WORDS)))
        begin
            hinit_reg[ctrl.h_idx] <= h_word;
        end
    end

    // Working variables
    always_ff @(posedge clk)
    begin
        if (ctrl.vars_init)
        begin
            a_reg <= hinit_reg[0];
            b_reg <= hinit_reg[1];
            c_reg <= hinit_reg[2];
            d_reg <= hinit_reg[3];
            e_reg <= hinit_reg[4];
        end
        else if (ctrl.round_en)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_word;
        end
    end

    // Final addition, one digest word at a time
    always_comb
    begin
        case (ctrl.sum_idx)
            3'd0: sum_word = hinit_reg[0] + a_reg;
            3'd1: sum_word = hinit_reg[1] + b_reg;
            3'd2: sum_word = hinit_reg[2] + c_reg;
            3'd3: sum_word = hinit_reg[3] + d_reg;
            3'd4: sum_word = hinit_reg[4] + e_reg;
            default: sum_word = '0;
        endcase
    end
endmodule

### hw/rtl/sha1_block_engine_registers.sv
// ----------------------------------------------------------------------------
// SHA-1 block engine register window
// Bus-facing register file with a one-block SHA-1 compression sequencer.
// ----------------------------------------------------------------------------
// Each request transfer is one 32-bit register access and yields one response
// transfer carrying the read data (zero for writes and unmapped words) and the
// interrupt level after the access. A plain read or write goes through the
// response state into the output register, and waits there while the output
// register still holds an untaken response. Digest and message words sit in
// single-port-read memories with a registered read. A config write with the
// start bit (and DMA disabled) runs one compression before its response,
// streaming the 16 message words and 5 chaining words out of the memories,
// running the rounds through the single round unit, writing the digest words
// back, then entering the response state. Both memories carry per-entry valid
// bits, so reset and soft reset take effect at once with no sweep. One access
// is in flight at a time; the next is taken once the response has been placed
// in the output register.
`include "sha1_block_engine_registers_macros.svh"

module sha1_block_engine_registers (
    input  logic         clk,
    input  logic         rst_n,
    sha1be_req_if.sink   req,
    sha1be_rsp_if.source rsp
);
    import sha1be_pkg::*;

    localparam int DIG_AW = $clog2(DIGEST_WORDS);
    localparam int MSG_AW = $clog2(MSG_WORDS);

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic [WORD_W-1:0] config_reg;
    logic [WORD_W-1:0] config_next;
    logic [WORD_W-1:0] reset_reg;
    logic [WORD_W-1:0] reset_next;
    logic [WORD_W-1:0] irq_enable_reg;
    logic [WORD_W-1:0] irq_enable_next;
    logic              irq_pending_reg;
    logic              irq_pending_next;
    logic [WORD_W-1:0] dma_control_reg;
    logic [WORD_W-1:0] dma_control_next;
    logic [WORD_W-1:0] dma_address_reg;
    logic [WORD_W-1:0] dma_address_next;
    logic [WORD_W-1:0] dma_length_reg;
    logic [WORD_W-1:0] dma_length_next;
    logic              custom_iv_reg;
    logic              custom_iv_next;

    rsp_kind_t         rsp_kind_reg;
    rsp_kind_t         rsp_kind_next;
    logic [WORD_W-1:0] direct_reg;
    logic [WORD_W-1:0] direct_next;
    logic [MSG_AW-1:0] idx_hold_reg;
    logic [MSG_AW-1:0] idx_hold_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] read_data_reg;
    logic [WORD_W-1:0] read_data_next;
    logic              irq_line_reg;
    logic              irq_line_next;

    logic              accept;
    logic              is_write;
    logic              is_digest;
    logic              is_msg;
    logic              start_req;
    logic              start_go;
    logic              soft_clear;
    logic              out_free;

    logic              dig_clear;
    logic              dig_we;
    logic [DIG_AW-1:0] dig_waddr;
    logic [WORD_W-1:0] dig_wdata;
    logic [DIG_AW-1:0] dig_raddr;
    logic [WORD_W-1:0] dig_rdata;
    logic              msg_we;
    logic [MSG_AW-1:0] msg_raddr;
    logic [WORD_W-1:0] msg_rdata;

    core_ctrl_t        core_ctrl;
    logic [WORD_W-1:0] h_word;
    logic [WORD_W-1:0] sum_word;
    logic [2:0]        load_idx;

    // Request decode
    assign accept     = req.valid && req.ready;
    assign is_write   = (req.op == OP_WRITE);
    assign is_digest  = (req.word_index >= IDX_DIGEST_BASE) &&
                        (req.word_index <= IDX_DIGEST_LAST);
    assign is_msg     = (req.word_index >= IDX_MSG_BASE) &&
                        (req.word_index <= IDX_MSG_LAST);
    assign start_req  = accept && is_write && (req.word_index == IDX_CONFIG) &&
                        req.write_data[CFG_START];
    assign start_go   = start_req && !dma_control_reg[0];
    assign soft_clear = accept && is_write && (req.word_index == IDX_RESET) &&
                        req.write_data[0];
    assign out_free   = !out_valid_reg || rsp.ready;
    assign load_idx   = 3'(cnt_reg - 7'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = start_go ? ST_LOAD : ST_RESP;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == CNT_LOAD_LAST)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == CNT_ROUND_LAST)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                if (cnt_reg == CNT_STORE_LAST)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, memory ports, round unit control
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);

        cnt_next = '0;
        if ((state_reg == ST_LOAD) || (state_reg == ST_ROUND) || (state_reg == ST_STORE))
        begin
            cnt_next = (state_next == state_reg) ? cnt_reg + 7'd1 : '0;
        end

        msg_we    = accept && is_write && is_msg;
        dig_clear = soft_clear || (start_req && dma_control_reg[0]);
        dig_we    = (accept && is_write && is_digest) || (state_reg == ST_STORE);
        dig_waddr = (state_reg == ST_STORE) ? cnt_reg[DIG_AW-1:0]
                                            : req.word_index[DIG_AW-1:0];
        dig_wdata = (state_reg == ST_STORE) ? sum_word : swap32(req.write_data);

        case (state_reg)
            ST_IDLE:
            begin
                msg_raddr = req.word_index[MSG_AW-1:0];
                dig_raddr = req.word_index[DIG_AW-1:0];
            end
            ST_LOAD:
            begin
                msg_raddr = cnt_reg[MSG_AW-1:0];
                dig_raddr = (cnt_reg < 7'(DIGEST_WORDS)) ? cnt_reg[DIG_AW-1:0] : '0;
            end
            default:
            begin
                msg_raddr = idx_hold_reg;
                dig_raddr = idx_hold_reg[DIG_AW-1:0];
            end
        endcase

        core_ctrl.sched_load = (state_reg == ST_LOAD) && (cnt_reg != '0);
        core_ctrl.h_load     = (state_reg == ST_LOAD) && (cnt_reg != '0) &&
                               (cnt_reg <= 7'(DIGEST_WORDS));
        core_ctrl.h_idx      = load_idx;
        core_ctrl.vars_init  = (state_reg == ST_LOAD) && (cnt_reg == CNT_LOAD_LAST);
        core_ctrl.round_en   = (state_reg == ST_ROUND);
        core_ctrl.rnd        = cnt_reg;
        core_ctrl.sum_idx    = cnt_reg[2:0];

        h_word = custom_iv_reg ? dig_rdata : iv_word(load_idx);
    end

    // Register file update and response capture
    always_comb
    begin
        config_next      = config_reg;
        reset_next       = reset_reg;
        irq_enable_next  = irq_enable_reg;
        irq_pending_next = irq_pending_reg;
        dma_control_next = dma_control_reg;
        dma_address_next = dma_address_reg;
        dma_length_next  = dma_length_reg;
        custom_iv_next   = custom_iv_reg;
        rsp_kind_next    = rsp_kind_reg;
        direct_next      = direct_reg;
        idx_hold_next    = idx_hold_reg;

        if (accept)
        begin
            idx_hold_next = req.word_index[MSG_AW-1:0];
            direct_next   = '0;
            rsp_kind_next = RSP_DIRECT;
            if (is_write)
            begin
                case (req.word_index)
                    IDX_CONFIG:
                    begin
                        config_next = req.write_data;
                        if (req.write_data[CFG_START])
                        begin
                            config_next[CFG_BUSY]  = 1'b0;
                            config_next[CFG_START] = 1'b0;
                            custom_iv_next = req.write_data[CFG_CUSTOM_IV];
                            if (req.write_data[CFG_IRQ] && irq_enable_reg[0])
                            begin
                                irq_pending_next = 1'b1;
                            end
                        end
                    end
                    IDX_RESET:
                    begin
                        reset_next = req.write_data;
                        if (req.write_data[0])
                        begin
                            config_next      = '0;
                            irq_enable_next  = '0;
                            irq_pending_next = 1'b0;
                            dma_control_next = '0;
                            dma_address_next = '0;
                            dma_length_next  = '0;
                        end
                    end
                    IDX_IRQ_ACK:
                    begin
                        if (req.write_data[0])
                        begin
                            irq_pending_next = 1'b0;
                        end
                    end
                    IDX_IRQ_EN:   irq_enable_next  = req.write_data;
                    IDX_DMA_CTRL: dma_control_next = req.write_data;
                    IDX_DMA_ADDR: dma_address_next = req.write_data;
                    IDX_DMA_LEN:  dma_length_next  = req.write_data;
                    default:      direct_next      = '0;
                endcase
            end
            else if (is_digest)
            begin
                rsp_kind_next = RSP_DIGEST;
            end
            else if (is_msg)
            begin
                rsp_kind_next = RSP_MSG;
            end
            else
            begin
                case (req.word_index)
                    IDX_CONFIG:   direct_next = config_reg;
                    IDX_RESET:    direct_next = reset_reg;
                    IDX_IRQ_ACK:  direct_next = {{(WORD_W - 1){1'b0}}, irq_pending_reg};
                    IDX_IRQ_EN:   direct_next = irq_enable_reg;
                    IDX_DMA_CTRL: direct_next = dma_control_reg;
                    IDX_DMA_ADDR: direct_next = dma_address_reg;
                    IDX_DMA_LEN:  direct_next = dma_length_reg;
                    default:      direct_next = '0;
                endcase
            end
        end
    end

    // Output register: load on response, drop after transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        irq_line_next  = irq_line_reg;
        if ((state_reg == ST_RESP) && out_free)
        begin
            out_valid_next = 1'b1;
            irq_line_next  = irq_pending_reg;
            case (rsp_kind_reg)
                RSP_DIGEST: read_data_next = swap32(dig_rdata);
                RSP_MSG:    read_data_next = msg_rdata;
                default:    read_data_next = direct_reg;
            endcase
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            config_reg      <= '0;
            reset_reg       <= '0;
            irq_enable_reg  <= '0;
            irq_pending_reg <= 1'b0;
            dma_control_reg <= '0;
            dma_address_reg <= '0;
            dma_length_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            config_reg      <= config_next;
            reset_reg       <= reset_next;
            irq_enable_reg  <= irq_enable_next;
            irq_pending_reg <= irq_pending_next;
            dma_control_reg <= dma_control_next;
            dma_address_reg <= dma_address_next;
            dma_length_reg  <= dma_length_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        custom_iv_reg <= custom_iv_next;
        rsp_kind_reg  <= rsp_kind_next;
        direct_reg    <= direct_next;
        idx_hold_reg  <= idx_hold_next;
        read_data_reg <= read_data_next;
        irq_line_reg  <= irq_line_next;
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;
    assign rsp.irq_line  = irq_line_reg;

    // Digest store
    sha1be_mem #(
        .DEPTH (DIGEST_WORDS)
    ) u_digest (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (dig_clear),
        .we    (dig_we),
        .waddr (dig_waddr),
        .wdata (dig_wdata),
        .raddr (dig_raddr),
        .rdata (dig_rdata)
    );

    // Message block store
    sha1be_mem #(
        .DEPTH (MSG_WORDS)
    ) u_message (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (soft_clear),
        .we    (msg_we),
        .waddr (req.word_index[MSG_AW-1:0]),
        .wdata (req.write_data),
        .raddr (msg_raddr),
        .rdata (msg_rdata)
    );

    // Compression round unit
    sha1be_core u_core (
        .clk      (clk),
        .ctrl     (core_ctrl),
        .msg_word (msg_rdata),
        .h_word   (h_word),
        .sum_word (sum_word)
    );

    // Checks
    `SHA1BE_ASSERT_NXT(a_start_enters_load, clk, rst_n, start_go, state_reg == ST_LOAD, "start did not enter load")
    `SHA1BE_ASSERT_IMP(a_store_in_range, clk, rst_n, state_reg == ST_STORE, cnt_reg <= CNT_STORE_LAST, "digest store index out of range")
    `SHA1BE_ASSERT_NXT(a_resp_to_output, clk, rst_n, (state_reg == ST_RESP) && out_free, rsp.valid, "response not placed in output register")
endmodule
